FILE: hdl/scrp_pkg.sv
// Shared types and constants for the symbolic Cholesky row-pattern block.
package scrp_pkg;

  localparam int IDX_W = 6;
  localparam int TAG_W = 6;
  localparam int PAR_W = 7;
  localparam int ENTRY_W = TAG_W + PAR_W;

  localparam logic [PAR_W-1:0] PARENT_NONE = 7'd64;

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_ENTRY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic             last;
  } result_t;

endpackage

FILE: hdl/symbolic_cholesky_row_pattern.sv
// Begin item: acceptance enters the flush state, which loads the result word into a free
//   output slot and returns to idle. Entry item: one tree node visited per cycle unless a
//   stalled output holds the walk (one node RAM read-check-write each), after the first read
//   at acceptance; flush then loads the final word. Ignored or no-new-node entries give none.
// Words drain through one output register; a stalled consumer holds the walk.
// Reset (rst, synchronous) clears the sequencer and output valid; node RAM is not cleared.
module symbolic_cholesky_row_pattern #(
  parameter int MAX_ORDER = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       req_type,
  input  logic [scrp_pkg::IDX_W-1:0] column_index,
  input  logic [scrp_pkg::IDX_W-1:0] row_index,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [scrp_pkg::IDX_W-1:0] factor_row,
  output logic [scrp_pkg::IDX_W-1:0] factor_column,
  output logic                       last
);

  import scrp_pkg::*;

  localparam int AW = $clog2(MAX_ORDER);

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               slot_free;
  logic               push;
  result_t            res;

  // Each word holds {visit tag, tree parent} of one node.
  scrp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ORDER)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scrp_walk #(
    .MAX_ORDER (MAX_ORDER)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .column_index (column_index),
    .row_index    (row_index),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .slot_free    (slot_free),
    .push         (push),
    .res          (res)
  );

  scrp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .slot_free     (slot_free),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .factor_row    (factor_row),
    .factor_column (factor_column),
    .last          (last)
  );

endmodule

FILE: hdl/scrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scrp_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/scrp_walk.sv
// Sequencer walking the elimination tree one node per cycle unless the output stalls.
module scrp_walk #(
  parameter int MAX_ORDER = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  req_type,
  input  logic [scrp_pkg::IDX_W-1:0]            column_index,
  input  logic [scrp_pkg::IDX_W-1:0]            row_index,
  output logic                                  ram_we,
  output logic [$clog2(MAX_ORDER)-1:0]          ram_waddr,
  output logic [scrp_pkg::ENTRY_W-1:0]          ram_wdata,
  output logic [$clog2(MAX_ORDER)-1:0]          ram_raddr,
  input  logic [scrp_pkg::ENTRY_W-1:0]          ram_rdata,
  input  logic                                  slot_free,
  output logic                                  push,
  output scrp_pkg::result_t                     res
);

  import scrp_pkg::*;

  localparam int AW = $clog2(MAX_ORDER);
  localparam logic [IDX_W:0] MAX_N = (IDX_W+1)'(MAX_ORDER);

  walk_state_t state, state_next;

  logic [IDX_W-1:0] col_k;
  logic [IDX_W-1:0] node;
  logic [IDX_W-1:0] pending;
  logic             pend_valid;

  logic [TAG_W-1:0] tag_rd;
  logic [PAR_W-1:0] par_rd;
  logic [PAR_W-1:0] par_new;
  logic [IDX_W-1:0] next_node;
  logic             hit;
  logic             walk_end;
  logic             step;
  logic             accept;
  logic             in_range;
  logic             is_walk;

  assign tag_rd    = ram_rdata[ENTRY_W-1:PAR_W];
  assign par_rd    = ram_rdata[PAR_W-1:0];
  assign hit       = (tag_rd == col_k);
  assign par_new   = (par_rd == PARENT_NONE) ? {1'b0, col_k} : par_rd;
  assign next_node = par_new[IDX_W-1:0];
  // A self loop only happens at the column node, which was just tagged.
  assign walk_end  = ({1'b0, next_node} >= MAX_N) || (next_node == node);
  assign step      = !hit && (!pend_valid || slot_free);

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && (state == ST_IDLE);
  assign in_range  = ({1'b0, column_index} < MAX_N);
  assign is_walk   = (req_type == REQ_ENTRY) && (row_index < column_index);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_range) begin
          if (req_type == REQ_BEGIN) begin
            state_next = ST_FLUSH;
          end else if (is_walk) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (hit) begin
          state_next = pend_valid ? ST_FLUSH : ST_IDLE;
        end else if (step && walk_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node[AW-1:0];
    ram_wdata = {col_k, PARENT_NONE};
    ram_raddr = node[AW-1:0];
    push      = 1'b0;
    res       = '{row: col_k, column: pending, last: 1'b0};
    unique case (state)
      ST_IDLE: begin
        ram_raddr = row_index[AW-1:0];
        if (accept && in_range && (req_type == REQ_BEGIN)) begin
          ram_we    = 1'b1;
          ram_waddr = column_index[AW-1:0];
          ram_wdata = {column_index, PARENT_NONE};
        end
      end
      ST_CHECK: begin
        if (step) begin
          // Tag the node, adopt it under this column if orphaned, read its parent.
          ram_we    = 1'b1;
          ram_wdata = {col_k, par_new};
          ram_raddr = next_node[AW-1:0];
          push      = pend_valid;
        end
      end
      ST_FLUSH: begin
        push     = slot_free;
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pend_valid <= (req_type == REQ_BEGIN);
          end
        end
        ST_CHECK: begin
          if (step) begin
            pend_valid <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (slot_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_k   <= column_index;
      node    <= row_index;
      pending <= column_index;
    end else if ((state == ST_CHECK) && step) begin
      pending <= node;
      node    <= next_node;
    end
  end

endmodule

FILE: hdl/scrp_out.sv
// Output register that holds one result word until the consumer takes it.
module scrp_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  scrp_pkg::result_t          res,
  output logic                       slot_free,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [scrp_pkg::IDX_W-1:0] factor_row,
  output logic [scrp_pkg::IDX_W-1:0] factor_column,
  output logic                       last
);

  import scrp_pkg::*;

  assign slot_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      factor_row    <= res.row;
      factor_column <= res.column;
      last          <= res.last;
    end
  end

endmodule

FILE: bench/symbolic_cholesky_row_pattern_tb.sv
// Testbench for the elimination-tree row-pattern block: stimulus, predictor and checks.
`timescale 1ns / 1ps

module symbolic_cholesky_row_pattern_tb;

  localparam int ORDER = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef logic [scrp_pkg::IDX_W-1:0] idx_t;

  // Tracks the tree state and the factor entries still owed by the block.
  class row_pattern_board;
    idx_t                        tag[ORDER];
    logic [scrp_pkg::PAR_W-1:0] parent[ORDER];
    bit                          written[ORDER];
    scrp_pkg::result_t           expected_entries[$];
    int                          errors;

    // True when a walk from row i for column k touches only nodes set by a begin word.
    function bit walk_defined(idx_t k, idx_t i);
      idx_t                        t[ORDER];
      logic [scrp_pkg::PAR_W-1:0] p[ORDER];
      idx_t                        node;
      t = tag;
      p = parent;
      if (i >= k) return 1'b1;
      node = i;
      for (int g = 0; g < ORDER; g++) begin
        if (!written[node]) return 1'b0;
        if (t[node] == k) break;
        if (p[node] == scrp_pkg::PARENT_NONE) p[node] = {1'b0, k};
        t[node] = k;
        if (p[node] >= ORDER) break;
        node = p[node][scrp_pkg::IDX_W-1:0];
      end
      return 1'b1;
    endfunction

    function void walk_column_word(logic kind, idx_t k, idx_t i);
      scrp_pkg::result_t walk[$];
      scrp_pkg::result_t nz;
      idx_t              node;
      if (kind == scrp_pkg::REQ_BEGIN) begin
        parent[k] = scrp_pkg::PARENT_NONE;
        tag[k] = k;
        written[k] = 1'b1;
        nz.row = k;
        nz.column = k;
        nz.last = 1'b1;
        expected_entries.push_back(nz);
        return;
      end
      if (i >= k) return;
      node = i;
      for (int g = 0; g < ORDER; g++) begin
        if (tag[node] == k) break;
        if (parent[node] == scrp_pkg::PARENT_NONE) parent[node] = {1'b0, k};
        nz.row = k;
        nz.column = node;
        nz.last = 1'b0;
        walk.push_back(nz);
        tag[node] = k;
        if (parent[node] >= ORDER) break;
        node = parent[node][scrp_pkg::IDX_W-1:0];
      end
      for (int j = 0; j < walk.size(); j++) begin
        nz = walk[j];
        nz.last = (j == walk.size() - 1);
        expected_entries.push_back(nz);
      end
    endfunction

    function void match_factor_entry(idx_t row, idx_t col, logic fin);
      scrp_pkg::result_t want;
      if (expected_entries.size() == 0) begin
        $error("factor entry row %0d column %0d with nothing expected", row, col);
        errors++;
        return;
      end
      want = expected_entries.pop_front();
      if (row !== want.row) begin
        $error("factor_row expected %0d actual %0d", want.row, row);
        errors++;
      end
      if (col !== want.column) begin
        $error("factor_column expected %0d actual %0d", want.column, col);
        errors++;
      end
      if (fin !== want.last) begin
        $error("last expected %0d actual %0d", want.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic req_type = scrp_pkg::REQ_BEGIN;
  idx_t column_index = '0;
  idx_t row_index = '0;
  logic res_valid;
  logic res_stall;
  idx_t factor_row;
  idx_t factor_column;
  logic last;

  row_pattern_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int entries_taken = 0;
  int words_counted = 0;
  bit hold_done = 1'b0;

  symbolic_cholesky_row_pattern uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .column_index(column_index),
    .row_index(row_index),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .factor_row(factor_row),
    .factor_column(factor_column),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("symbolic_cholesky_row_pattern_tb failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold so the block backs up into its input.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && entries_taken >= 40) begin
        hold_done = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      board.match_factor_entry(factor_row, factor_column, last);
      entries_taken++;
    end
  end

  task automatic send_word(input logic kind, input int k, input int r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    column_index <= idx_t'(k);
    row_index <= idx_t'(r);
    do @(posedge clk); while (req_stall);
    board.walk_column_word(kind, idx_t'(k), idx_t'(r));
    if (kind == scrp_pkg::REQ_BEGIN || r < k) words_counted++;
  endtask

  task automatic send_begin(input int k);
    send_word(scrp_pkg::REQ_BEGIN, k, int'($urandom_range(0, ORDER - 1)));
  endtask

  // Drop an entry whose walk would reach a node that no begin word has set.
  task automatic send_entry(input int k, input int r);
    if (board.walk_defined(idx_t'(k), idx_t'(r))) send_word(scrp_pkg::REQ_ENTRY, k, r);
  endtask

  task automatic send_matrix(input int order);
    int extra;
    for (int k = 0; k < order; k++) begin
      send_begin(k);
      if (k > 0 && $urandom_range(0, 1) == 1) send_entry(k, k - 1);
      extra = (order > 16) ? 1 : 3;
      if (k > 0) begin
        repeat ($urandom_range(0, (k < extra) ? k : extra))
          send_entry(k, $urandom_range(0, k - 1));
      end
      if ($urandom_range(0, 7) == 0)
        send_word(scrp_pkg::REQ_ENTRY, k, $urandom_range(k, ORDER - 1));
    end
  endtask

  task automatic send_noise();
    int   k;
    int   r;
    bit   sent;
    repeat ($urandom_range(3, 6)) begin
      case ($urandom_range(0, 3))
        0: send_begin($urandom_range(0, ORDER - 1));
        3: begin
          k = $urandom_range(0, ORDER - 1);
          send_word(scrp_pkg::REQ_ENTRY, k, $urandom_range(k, ORDER - 1));
        end
        default: begin
          sent = 1'b0;
          for (int t = 0; t < 8 && !sent; t++) begin
            k = $urandom_range(1, ORDER - 1);
            r = $urandom_range(0, k - 1);
            if (board.walk_defined(idx_t'(k), idx_t'(r))) begin
              send_word(scrp_pkg::REQ_ENTRY, k, r);
              sent = 1'b1;
            end
          end
          if (!sent) send_begin(k);
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: small tree by hand, ignored rows, repeated walks, top indices.
    send_begin(0);
    send_word(scrp_pkg::REQ_ENTRY, 0, 0);
    send_begin(1);
    send_entry(1, 0);
    send_entry(1, 0);
    send_word(scrp_pkg::REQ_ENTRY, 1, 63);
    send_begin(2);
    send_entry(2, 0);
    send_entry(2, 1);
    send_begin(3);
    send_entry(3, 2);
    send_entry(3, 0);
    send_begin(62);
    send_begin(63);
    send_entry(63, 62);
    send_word(scrp_pkg::REQ_ENTRY, 63, 63);
    send_word(scrp_pkg::REQ_ENTRY, 62, 63);
    send_entry(63, 0);
    // revisit column 3 without a fresh begin; the walk runs on the stale tree
    send_entry(3, 1);
    send_entry(3, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      words_counted = 0;
      if (ph == 3) send_matrix(ORDER / 2);
      while (words_counted < 20) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_matrix($urandom_range(2, 10));
      end
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (board.expected_entries.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.expected_entries.size() == 0)
      $display("symbolic_cholesky_row_pattern_tb passed");
    else
      $display("symbolic_cholesky_row_pattern_tb failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/scrp_pkg.sv
hdl/scrp_ram.sv
hdl/scrp_walk.sv
hdl/scrp_out.sv
hdl/symbolic_cholesky_row_pattern.sv
bench/symbolic_cholesky_row_pattern_tb.sv
